// ===== hdl/imd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pkg - shared types and constants for the integer matrix determinant
// Field widths of the request, result and control register, plus the
// status word that the column tuple unit hands to the sequencer.
// ----------------------------------------------------------------------------
package imd_pkg;

   localparam int ELEM_W = 8;    // matrix element, two's complement
   localparam int DET_W  = 64;   // determinant, two's complement
   localparam int CSR_W  = 3;    // size_in_use register

   // status of the current column tuple
   typedef struct packed {
      logic dup;    // some column appears twice: term is zero
      logic odd;    // odd inversion count: term is subtracted
      logic wrap;   // this is the last tuple of the sweep
   } imd_tuple_status_type;

endpackage : imd_pkg
`default_nettype wire

// ===== hdl/imd_tuple.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imd_tuple - column tuple counter
// Holds one column index per row, steps them like an odometer (last row
// fastest) and reports repeated columns, inversion parity and wrap-around.
// ----------------------------------------------------------------------------
module imd_tuple #(
   parameter  int MAX_ORDER = 4,
   localparam int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
   localparam int OW = $clog2(MAX_ORDER + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [OW-1:0]                      order,
   input  wire logic                               clear,
   input  wire logic                               advance,
   input  wire logic [CW-1:0]                      row_sel,
   output logic [CW-1:0]                           col_sel,
   output imd_pkg::imd_tuple_status_type           status
);

   logic [CW-1:0] col_ff [MAX_ORDER];
   logic [CW-1:0] col_in [MAX_ORDER];
   logic [CW-1:0] top_col;
   logic          carry;
   logic          dup;
   logic          odd;

   assign top_col = CW'(order - OW'(1));

   // pairwise compare over the active rows
   always_comb begin
      dup = 1'b0;
      odd = 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         for (int j = i + 1; j < MAX_ORDER; j++) begin
            if (j < int'(order)) begin
               if (col_ff[i] == col_ff[j]) dup = 1'b1;
               if (col_ff[i] > col_ff[j]) odd = ~odd;
            end
         end
      end
   end

   // odometer step, last active row fastest
   always_comb begin
      carry = 1'b1;
      for (int k = MAX_ORDER - 1; k >= 0; k--) begin
         col_in[k] = col_ff[k];
         if (k < int'(order) && carry) begin
            if (col_ff[k] == top_col) begin
               col_in[k] = '0;
            end else begin
               col_in[k] = col_ff[k] + CW'(1);
               carry     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int k = 0; k < MAX_ORDER; k++) col_ff[k] <= '0;
      end else if (advance) begin
         col_ff <= col_in;
      end
   end

   assign col_sel = col_ff[row_sel];
   assign status  = '{dup: dup, odd: odd, wrap: carry};

endmodule : imd_tuple
`default_nettype wire

// ===== hdl/integer_matrix_determinant.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_determinant - exact determinant of a small integer matrix
// Loads a square matrix of signed 8-bit elements and returns its exact
// 64-bit determinant by Leibniz expansion on one shared multiplier.
// ----------------------------------------------------------------------------
// Elements arrive on the req_ channel in row-major order, one request per
// cycle while the block is idle; the matrix order n comes from the size
// register (0 reads as 1, values above MAX_ORDER read as MAX_ORDER), and any
// write to that register restarts loading at element (0,0). After the last
// element req_stall goes high and the sequencer walks all n^n column tuples:
// a tuple that repeats a column is skipped in the check state, and a true
// permutation takes one store read and one 64x8 multiply per row, then one
// signed accumulate. The pass is bounded by the single multiplier and the
// one read port of the element store. The result then sits on
// rsp_determinant with rsp_valid high until taken, after which the block
// takes requests again.
// ----------------------------------------------------------------------------
module integer_matrix_determinant #(
   parameter int MAX_ORDER = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // element requests
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [imd_pkg::ELEM_W-1:0]  req_element,
   // determinant results
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [imd_pkg::DET_W-1:0]        rsp_determinant,
   // size register
   input  wire logic                               csr_wr_en,
   input  wire logic [imd_pkg::CSR_W-1:0]          csr_wr_data
);

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int OW    = $clog2(MAX_ORDER + 1);
   localparam int PW    = imd_pkg::DET_W + imd_pkg::ELEM_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // loading elements
   localparam logic [2:0] S_CHECK = 3'd1;  // inspect column tuple
   localparam logic [2:0] S_READ  = 3'd2;  // fetch element of current row
   localparam logic [2:0] S_MUL   = 3'd3;  // fold element into term
   localparam logic [2:0] S_ACC   = 3'd4;  // add or subtract term
   localparam logic [2:0] S_OUT   = 3'd5;  // hold result

   localparam logic [imd_pkg::CSR_W-1:0] SIZE_RESET = imd_pkg::CSR_W'(4);

   // clamp register value to a usable order
   function automatic logic [OW-1:0] eff_order(input logic [imd_pkg::CSR_W-1:0] v);
      if (v == '0) return OW'(1);
      else if (int'(v) > MAX_ORDER) return OW'(MAX_ORDER);
      else return OW'(v);
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [OW-1:0] order_ff;
   logic [AW-1:0] load_ff;
   logic [AW-1:0] total_m1;
   logic          req_take;
   logic          load_done;

   // element store, registered read
   logic signed [imd_pkg::ELEM_W-1:0] store_ff [DEPTH];
   logic signed [imd_pkg::ELEM_W-1:0] rd_ff;
   logic [AW-1:0]                     rd_addr;

   // term / sum datapath
   logic signed [imd_pkg::DET_W-1:0] term_ff, term_in;
   logic signed [imd_pkg::DET_W-1:0] sum_ff, sum_in;
   logic signed [PW-1:0]             prod;
   logic [CW-1:0]                    row_ff, row_in;
   logic [AW-1:0]                    base_ff, base_in;
   logic                             last_row;

   // tuple unit
   logic                          tup_clear;
   logic                          tup_advance;
   logic [CW-1:0]                 col_sel;
   imd_pkg::imd_tuple_status_type tup_status;

   assign total_m1  = AW'(int'(order_ff) * int'(order_ff) - 1);
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_done = req_take && (load_ff == total_m1);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_determinant = sum_ff;

   // ---- size register and load counter ----
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= eff_order(SIZE_RESET);
         load_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= eff_order(csr_wr_data);
            load_ff  <= '0;
         end else if (load_done) begin
            load_ff  <= '0;
         end else if (req_take) begin
            load_ff  <= load_ff + AW'(1);
         end
      end
   end

   // ---- element store ----
   assign rd_addr = base_ff + AW'(col_sel);

   always_ff @(posedge clock) begin
      if (req_take) store_ff[load_ff] <= req_element;
      rd_ff <= store_ff[rd_addr];
   end

   // ---- column tuple unit ----
   assign tup_clear = load_done;

   imd_tuple #(
      .MAX_ORDER (MAX_ORDER)
   ) u_tuple (
      .clock   (clock),
      .reset   (reset),
      .order   (order_ff),
      .clear   (tup_clear),
      .advance (tup_advance),
      .row_sel (row_ff),
      .col_sel (col_sel),
      .status  (tup_status)
   );

   // ---- shared multiplier: one row per pass ----
   assign prod     = term_ff * rd_ff;
   assign last_row = (row_ff == CW'(order_ff - OW'(1)));

   // ---- sequencer ----
   always_comb begin
      state_in    = state_ff;
      term_in     = term_ff;
      sum_in      = sum_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      tup_advance = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (load_done) begin
               sum_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (tup_status.dup) begin
               // repeated column: skip tuple
               tup_advance = 1'b1;
               if (tup_status.wrap) state_in = S_OUT;
            end else begin
               term_in  = imd_pkg::DET_W'(1);
               row_in   = '0;
               base_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            term_in = prod[imd_pkg::DET_W-1:0];
            if (last_row) begin
               state_in = S_ACC;
            end else begin
               row_in   = row_ff + CW'(1);
               base_in  = base_ff + AW'(order_ff);
               state_in = S_READ;
            end
         end
         S_ACC: begin
            sum_in      = tup_status.odd ? (sum_ff - term_ff) : (sum_ff + term_ff);
            tup_advance = 1'b1;
            state_in    = tup_status.wrap ? S_OUT : S_CHECK;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      sum_ff  <= sum_in;
      row_ff  <= row_in;
      base_ff <= base_in;
   end

endmodule : integer_matrix_determinant
`default_nettype wire

// ===== tb/tb_integer_matrix_determinant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_matrix_determinant - self-checking bench for the determinant block
// Streams square matrices of signed 8-bit elements at every order setting,
// including out-of-range sizes and loads cut short by a size change, predicts
// each exact 64-bit determinant by full permutation expansion and checks every
// returned result in order, under random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_integer_matrix_determinant;

   localparam int MAX_ORDER      = 4;
   localparam int STORE_DEPTH    = MAX_ORDER * MAX_ORDER;
   localparam int IDLE_PERCENT   = 23;     // idle share for each side
   localparam int SETTLE_CYCLES  = 500;    // covers one full pass at order 4
   localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
   localparam int RANDOM_ITEMS   = 450;

   localparam logic [imd_pkg::CSR_W-1:0] SIZE_AT_RESET = imd_pkg::CSR_W'(4);

   // how the contents of one random matrix are drawn
   typedef enum int {
      FILL_RANDOM,     // any 8-bit value
      FILL_EXTREME,    // -128, 127, 0, -1, 1
      FILL_SINGULAR,   // second row copies the first
      FILL_SMALL       // -3 .. 3, many cancellations
   } fill_kind_type;

   // ---------------------------------------------------------------------
   // clock, reset and block inputs (all known from time zero)
   // ---------------------------------------------------------------------
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic signed [imd_pkg::ELEM_W-1:0]   req_element = '0;
   logic                                rsp_stall   = 1'b0;
   logic                                csr_wr_en   = 1'b0;
   logic [imd_pkg::CSR_W-1:0]           csr_wr_data = '0;

   logic                                req_stall;
   logic                                rsp_valid;
   logic signed [imd_pkg::DET_W-1:0]    rsp_determinant;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_matrix_determinant #(
      .MAX_ORDER       (MAX_ORDER)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_determinant (rsp_determinant),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // shared bench state
   // ---------------------------------------------------------------------
   logic signed [imd_pkg::ELEM_W-1:0] pending_elements [$];   // requests not yet offered
   logic signed [imd_pkg::DET_W-1:0]  expected_dets [$];      // determinants owed

   bit steady_phase  = 1'b0;   // suppresses random idling on both sides
   int hold_requests = 0;      // bumped by the stimulus to ask for a hold-off
   int hold_served   = 0;
   int hold_left     = 0;

   int items_queued  = 0;
   int dets_checked  = 0;
   int mismatches    = 0;
   int size_writes   = 0;
   int quiet_cycles  = 0;

   // ---------------------------------------------------------------------
   // determinant predictor: its own copy of the size register, the element
   // store and the load position
   // ---------------------------------------------------------------------
   logic [imd_pkg::CSR_W-1:0]         size_reg = SIZE_AT_RESET;
   logic signed [imd_pkg::ELEM_W-1:0] element_store [STORE_DEPTH];
   int                                loaded = 0;

   // size 0 reads as order 1, anything above MAX_ORDER clamps to MAX_ORDER
   function automatic int order_of(input logic [imd_pkg::CSR_W-1:0] size);
      if (size == 0)
         return 1;
      if (size > MAX_ORDER)
         return MAX_ORDER;
      return int'(size);
   endfunction

   // sum over every column tuple; tuples that reuse a column are skipped,
   // the rest are signed by the parity of their inversion count
   function automatic logic signed [imd_pkg::DET_W-1:0] expand_determinant(input int n);
      int                               pick [MAX_ORDER];
      int                               tuples, code, r, q, inversions;
      bit                               clash;
      logic signed [imd_pkg::DET_W-1:0] term, total;
      total  = '0;
      tuples = 1;
      for (r = 0; r < n; r++)
         tuples *= n;
      for (code = 0; code < tuples; code++) begin
         q = code;
         for (r = n - 1; r >= 0; r--) begin
            pick[r] = q % n;
            q       = q / n;
         end
         clash      = 1'b0;
         inversions = 0;
         for (r = 0; r < n; r++) begin
            for (q = r + 1; q < n; q++) begin
               if (pick[r] == pick[q])
                  clash = 1'b1;
               if (pick[r] > pick[q])
                  inversions++;
            end
         end
         if (!clash) begin
            term = 1;
            for (r = 0; r < n; r++)
               term = term * element_store[r * n + pick[r]];
            total = inversions[0] ? total - term : total + term;
         end
      end
      return total;
   endfunction

   // one accepted element; the last one of a matrix owes a determinant
   function automatic void absorb_element(input logic signed [imd_pkg::ELEM_W-1:0] value);
      int n;
      n = order_of(size_reg);
      if (loaded >= n * n)
         loaded = 0;
      element_store[loaded] = value;
      loaded++;
      if (loaded == n * n) begin
         loaded = 0;
         expected_dets.push_back(expand_determinant(n));
      end
   endfunction

   // ---------------------------------------------------------------------
   // driver: offers queued elements, tracks size writes and accepted
   // requests for the predictor. The payload only moves once the current
   // request has been taken, and valid is raised without looking at req_stall.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         size_reg   = SIZE_AT_RESET;
         loaded     = 0;
      end else begin
         if (csr_wr_en) begin
            size_reg = csr_wr_data;
            loaded   = 0;          // any size write restarts loading
         end
         if (req_valid && !req_stall)
            absorb_element(req_element);
         if (!req_valid || !req_stall) begin
            if (pending_elements.size() != 0 &&
                (steady_phase || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_valid   <= 1'b1;
               req_element <= pending_elements.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks every taken determinant against the oldest one owed,
   // and drives rsp_stall (random idling plus the counted hold-off)
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic signed [imd_pkg::DET_W-1:0] owed;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dets.size() == 0) begin
               mismatches++;
               $display("%0t: determinant %0d returned with no matrix owed",
                        $time, rsp_determinant);
            end else begin
               owed = expected_dets.pop_front();
               dets_checked++;
               if (rsp_determinant !== owed) begin
                  mismatches++;
                  $display("%0t: determinant mismatch, expected %0d, actual %0d",
                           $time, owed, rsp_determinant);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_stall <= (hold_left != 0) || (hold_served != hold_requests) ||
                      (!steady_phase && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: a long run of cycles without any handshake ends the run
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus helpers (run from the initial block, step on the falling edge)
   // ---------------------------------------------------------------------
   task automatic offer(input logic signed [imd_pkg::ELEM_W-1:0] value);
      pending_elements.push_back(value);
      items_queued++;
   endtask

   // Sender pause: wait for every request to be taken and every owed
   // determinant to come back, then give the block one full pass worth of
   // cycles in case something is still in flight.
   task automatic settle();
      do
         @(negedge clock);
      while (pending_elements.size() != 0 || req_valid || expected_dets.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // size register writes only happen with the block idle
   task automatic write_size(input logic [imd_pkg::CSR_W-1:0] size);
      settle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_writes++;
      @(negedge clock);
   endtask

   task automatic queue_matrix(input int n, input fill_kind_type fill);
      logic signed [imd_pkg::ELEM_W-1:0] grid [STORE_DEPTH];
      int                                k;
      for (k = 0; k < n * n; k++) begin
         case (fill)
            FILL_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       grid[k] = -8'sd128;
                  1:       grid[k] = 8'sd127;
                  2:       grid[k] = 8'sd0;
                  3:       grid[k] = -8'sd1;
                  default: grid[k] = 8'sd1;
               endcase
            end
            FILL_SINGULAR: begin
               if (n > 1 && k / n == 1)
                  grid[k] = grid[k - n];
               else
                  grid[k] = imd_pkg::ELEM_W'($urandom_range(0, 255));
            end
            FILL_SMALL: grid[k] = imd_pkg::ELEM_W'(int'($urandom_range(0, 6)) - 3);
            default:    grid[k] = imd_pkg::ELEM_W'($urandom_range(0, 255));
         endcase
         offer(grid[k]);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [imd_pkg::CSR_W-1:0] size;
      int                        n, k, count, phase;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part --------------------------------------------------
      // order 4 from reset: -128 on the diagonal, 127 elsewhere
      for (k = 0; k < STORE_DEPTH; k++)
         offer((k % (MAX_ORDER + 1) == 0) ? -8'sd128 : 8'sd127);

      // order 1: the determinant is the element itself, both extremes
      write_size(3'd1);
      offer(-8'sd128);
      offer(8'sd127);

      // size zero behaves as order 1
      write_size(3'd0);
      offer(-8'sd1);

      // order 3 load cut short by a size change, then a full order 2 matrix
      write_size(3'd3);
      offer(8'sd5);
      offer(-8'sd7);
      offer(8'sd9);
      write_size(3'd2);
      offer(8'sd127);
      offer(-8'sd128);
      offer(-8'sd128);
      offer(8'sd127);

      // --- backpressure: receiver holds off while the sender keeps offering,
      // so the block sits on a result and stalls its input
      write_size(3'd2);
      hold_requests++;
      for (k = 0; k < 5; k++)
         queue_matrix(2, FILL_RANDOM);

      // --- random part ----------------------------------------------------
      // Each phase: a size write (every code 0..7 shows up, small orders
      // favored), a batch of whole matrices and now and then a broken load
      // that the next size write throws away.
      phase = 0;
      while (items_queued < RANDOM_ITEMS) begin
         if (phase < 8)
            size = phase[imd_pkg::CSR_W-1:0] ^ 3'b101;
         else if ($urandom_range(0, 3) == 0)
            size = imd_pkg::CSR_W'($urandom_range(0, 7));
         else
            size = imd_pkg::CSR_W'($urandom_range(1, 3));
         write_size(size);
         n = order_of(size);
         steady_phase = (phase == 3 || phase == 4);   // long stretch with no idling
         count = (n == MAX_ORDER) ? $urandom_range(1, 2) : $urandom_range(2, 8);
         for (k = 0; k < count; k++)
            queue_matrix(n, fill_kind_type'($urandom_range(0, 3)));
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, n * n - 1);
            for (k = 0; k < count; k++)
               offer(imd_pkg::ELEM_W'($urandom_range(0, 255)));
         end
         phase++;
      end
      steady_phase = 1'b0;

      // --- drain and report -------------------------------------------------
      settle();
      $display("Sent %0d element requests over %0d size settings; %0d determinants checked",
               items_queued, size_writes, dets_checked);
      if (mismatches == 0 && expected_dets.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/imd_pkg.sv
hdl/imd_tuple.sv
hdl/integer_matrix_determinant.sv
tb/tb_integer_matrix_determinant.sv
